### rtl/core/imh_pkg.sv
package imh_pkg;

  localparam int ID_W     = 10;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 11;
  localparam int ID_DEPTH = 1024;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_CHANGE = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_QUERY  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [KEY_W-1:0] key_value;
    logic [ID_W-1:0]         item_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    min_valid;
    logic [ID_W-1:0]         min_id;
    logic signed [KEY_W-1:0] min_key;
    logic [ID_W-1:0]         popped_id;
    logic                    query_present;
    logic signed [KEY_W-1:0] query_key;
    logic [CNT_W-1:0]        item_count;
  } out_item_t;

  // Sequencer steps, one-hot; the current step is the command to the datapath.
  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_LOOK  = 15'h0002,
    S_LAST1 = 15'h0004,
    S_LAST2 = 15'h0008,
    S_UP    = 15'h0010,
    S_UP_R1 = 15'h0020,
    S_UP_R2 = 15'h0040,
    S_DN    = 15'h0080,
    S_DL1   = 15'h0100,
    S_DL2   = 15'h0200,
    S_DR    = 15'h0400,
    S_FIN   = 15'h0800,
    S_FIN1  = 15'h1000,
    S_FIN2  = 15'h2000,
    S_CLR   = 15'h4000
  } step_t;

  typedef struct packed {
    logic       in_xfer;
    logic [2:0] cmd;
    logic       valid_id;
    logic       present;
    logic       empty;
    logic       last_only;
    logic       pos_last;
    logic       rm_down;
    logic       at_root;
    logic       up_move;
    logic       try_down;
    logic       moved;
    logic       lc_ok;
    logic       rc_ok;
    logic       dn_move;
    logic       clr_done;
    logic       out_free;
  } dp_status_t;

endpackage

### rtl/core/imh_ctrl.sv
module imh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  imh_pkg::dp_status_t stat,
  output imh_pkg::step_t      step,
  output logic                in_stall
);
  import imh_pkg::*;

  step_t step_next;
  logic  clr_reset;

  // The input side is open only between operations.
  assign in_stall = (step != S_IDLE);

  // Step register; reset starts a sweep of the presence memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_CLR;
      clr_reset <= 1'b1;
    end else begin
      step <= step_next;
      if (step == S_CLR && stat.clr_done) begin
        clr_reset <= 1'b0;
      end
    end
  end

  // Next step.
  always_comb begin
    step_next = step;
    unique case (step)
      S_IDLE: begin
        if (stat.in_xfer) step_next = S_LOOK;
      end
      S_LOOK: begin
        case (stat.cmd)
          CMD_INSERT: step_next = (stat.valid_id && !stat.present) ? S_UP : S_FIN;
          CMD_CHANGE: step_next = stat.present ? S_UP : S_FIN;
          CMD_REMOVE: begin
            if (!stat.present || stat.pos_last) step_next = S_FIN;
            else step_next = S_LAST1;
          end
          CMD_POP: begin
            if (stat.empty || stat.last_only) step_next = S_FIN;
            else step_next = S_LAST1;
          end
          CMD_CLEAR: step_next = S_CLR;
          default: step_next = S_FIN;
        endcase
      end
      S_LAST1: step_next = S_LAST2;
      S_LAST2: begin
        if (stat.cmd == CMD_POP || stat.rm_down) step_next = S_DN;
        else step_next = S_UP;
      end
      S_UP: begin
        if (!stat.at_root) step_next = S_UP_R1;
        else if (stat.try_down && !stat.moved) step_next = S_DN;
        else step_next = S_FIN;
      end
      S_UP_R1: step_next = S_UP_R2;
      S_UP_R2: begin
        if (stat.up_move) step_next = S_UP;
        else if (stat.try_down && !stat.moved) step_next = S_DN;
        else step_next = S_FIN;
      end
      S_DN: step_next = stat.lc_ok ? S_DL1 : S_FIN;
      S_DL1: step_next = S_DL2;
      S_DL2: begin
        if (stat.rc_ok) step_next = S_DR;
        else step_next = stat.dn_move ? S_DN : S_FIN;
      end
      S_DR: step_next = stat.dn_move ? S_DN : S_FIN;
      S_FIN: step_next = S_FIN1;
      S_FIN1: step_next = S_FIN2;
      S_FIN2: begin
        if (stat.out_free) step_next = S_IDLE;
      end
      S_CLR: begin
        if (stat.clr_done) step_next = clr_reset ? S_IDLE : S_FIN;
      end
      default: step_next = S_IDLE;
    endcase
  end

endmodule

### rtl/core/imh_dpath.sv
module imh_dpath #(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  imh_pkg::step_t      step,
  input  logic                in_xfer,
  input  imh_pkg::in_item_t   in_data,
  output imh_pkg::dp_status_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output imh_pkg::out_item_t  out_data
);
  import imh_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = SW + 1;
  localparam int IW = $clog2(ID_DEPTH);

  // Memories.
  logic [ID_W-1:0]         slot_mem [CAPACITY];
  logic signed [KEY_W-1:0] key_mem  [ID_DEPTH];
  logic [SW-1:0]           pos_mem  [ID_DEPTH];
  logic                    pres_mem [ID_DEPTH];

  logic                    slot_we, key_we, pos_we, pres_we;
  logic [SW-1:0]           slot_waddr, slot_raddr, pos_wdata;
  logic [ID_W-1:0]         slot_wdata, slot_rd;
  logic [IW-1:0]           key_waddr, key_raddr, pos_waddr, pos_raddr;
  logic [IW-1:0]           pres_waddr, pres_raddr;
  logic signed [KEY_W-1:0] key_wdata, key_rd;
  logic [SW-1:0]           pos_rd;
  logic                    pres_wdata, pres_rd;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rd <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (pres_we) pres_mem[pres_waddr] <= pres_wdata;
    pres_rd <= pres_mem[pres_raddr];
  end

  // Working registers.
  logic [2:0]              cmd_r;
  logic signed [KEY_W-1:0] key_r, ckey, ckey_next, lkey, lkey_next, old_key, old_key_next;
  logic [ID_W-1:0]         id_r, cid, cid_next, pid, pid_next, lid, lid_next, rid, rid_next;
  logic [ID_W-1:0]         root, root_next, popped, popped_next;
  logic [SW-1:0]           pos, pos_next;
  logic [PW-1:0]           count, count_next;
  logic [IW-1:0]           clr_idx;
  logic [1:0]              status, status_next;
  logic                    q_present, q_present_next, try_down, try_down_next;
  logic                    moved, moved_next;
  logic signed [KEY_W-1:0] q_key, q_key_next;

  // Derived positions and flags.
  logic [PW-1:0]           cnt_m1;
  logic [SW-1:0]           parent;
  logic [PW-1:0]           lc;
  logic [PW:0]             rc;
  logic                    valid_id, present, lc_ok, rc_ok, right_pick, dn_move;
  logic signed [KEY_W-1:0] pick_key;
  logic [ID_W-1:0]         pick_id;
  logic [SW-1:0]           pick_pos;
  logic                    place_en;
  logic [SW-1:0]           place_pos;
  logic [ID_W-1:0]         place_id;
  logic                    out_free, out_load;

  assign cnt_m1   = count - 1'b1;
  assign parent   = SW'(pos - 1'b1) >> 1;
  assign lc       = {pos, 1'b1};
  assign rc       = {1'b0, lc} + 1'b1;
  assign valid_id = 32'(id_r) < 32'(CAPACITY);
  assign present  = valid_id && pres_rd;
  assign lc_ok    = lc < count;
  assign rc_ok    = rc < {1'b0, count};

  // Child choice; in DL2 only the left child exists, in DR both are read.
  assign right_pick = (step == S_DR) && (key_rd < lkey);
  assign pick_key   = (step == S_DR && !right_pick) ? lkey : key_rd;
  assign pick_id    = right_pick ? rid : lid;
  assign pick_pos   = right_pick ? rc[SW-1:0] : lc[SW-1:0];
  assign dn_move    = pick_key < ckey;

  assign out_free = !out_valid || !out_stall;
  assign out_load = (step == S_FIN2) && out_free;

  // Status to the sequencer.
  always_comb begin
    stat.in_xfer   = in_xfer;
    stat.cmd       = cmd_r;
    stat.valid_id  = valid_id;
    stat.present   = present;
    stat.empty     = (count == '0);
    stat.last_only = (count == PW'(1));
    stat.pos_last  = (pos_rd == cnt_m1[SW-1:0]);
    stat.rm_down   = old_key < key_rd;
    stat.at_root   = (pos == '0);
    stat.up_move   = ckey < key_rd;
    stat.try_down  = try_down;
    stat.moved     = moved;
    stat.lc_ok     = lc_ok;
    stat.rc_ok     = rc_ok;
    stat.dn_move   = dn_move;
    stat.clr_done  = (clr_idx == IW'(ID_DEPTH - 1));
    stat.out_free  = out_free;
  end

  // Memory addressing, register updates and the slot placement of each step.
  always_comb begin
    slot_we = 1'b0; key_we = 1'b0; pos_we = 1'b0; pres_we = 1'b0;
    slot_raddr = '0;
    key_raddr  = id_r[IW-1:0];
    pos_raddr  = id_r[IW-1:0];
    pres_raddr = id_r[IW-1:0];
    key_waddr  = id_r[IW-1:0];
    key_wdata  = key_r;
    pres_waddr = id_r[IW-1:0];
    pres_wdata = 1'b0;
    place_en = 1'b0; place_pos = pos; place_id = cid;
    cid_next = cid; ckey_next = ckey; pid_next = pid; lid_next = lid; rid_next = rid;
    lkey_next = lkey; old_key_next = old_key; root_next = root; popped_next = popped;
    pos_next = pos; count_next = count; status_next = status;
    q_present_next = q_present; q_key_next = q_key;
    try_down_next = try_down; moved_next = moved;
    unique case (step)
      S_IDLE: begin
        key_raddr  = in_data.item_id[IW-1:0];
        pos_raddr  = in_data.item_id[IW-1:0];
        pres_raddr = in_data.item_id[IW-1:0];
      end
      S_LOOK: begin
        status_next = ST_OK; popped_next = '0;
        q_present_next = 1'b0; q_key_next = '0;
        moved_next = 1'b0; try_down_next = 1'b0;
        slot_raddr = cnt_m1[SW-1:0];
        case (cmd_r)
          CMD_INSERT: begin
            if (!valid_id) status_next = ST_ABSENT;
            else if (present) status_next = ST_PRESENT;
            else begin
              key_we = 1'b1;
              pres_we = 1'b1; pres_wdata = 1'b1;
              cid_next = id_r; ckey_next = key_r;
              pos_next = count[SW-1:0];
              count_next = count + 1'b1;
            end
          end
          CMD_CHANGE: begin
            if (!present) status_next = ST_ABSENT;
            else begin
              key_we = 1'b1;
              cid_next = id_r; ckey_next = key_r;
              pos_next = pos_rd;
              try_down_next = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (!present) status_next = ST_ABSENT;
            else begin
              pres_we = 1'b1;
              count_next = cnt_m1;
              pos_next = pos_rd;
              old_key_next = key_rd;
            end
          end
          CMD_POP: begin
            if (count == '0) status_next = ST_EMPTY;
            else begin
              // The slot memory was read at the root during the transfer cycle.
              popped_next = slot_rd;
              pres_we = 1'b1; pres_waddr = slot_rd[IW-1:0];
              count_next = cnt_m1;
              pos_next = '0;
            end
          end
          CMD_QUERY: begin
            if (present) begin
              q_present_next = 1'b1; q_key_next = key_rd;
            end else begin
              status_next = ST_ABSENT;
            end
          end
          default: ;
        endcase
      end
      S_LAST1: begin
        cid_next = slot_rd;
        key_raddr = slot_rd[IW-1:0];
      end
      S_LAST2: begin
        ckey_next = key_rd;
        moved_next = 1'b0;
      end
      S_UP: begin
        slot_raddr = parent;
        if (pos == '0 && !(try_down && !moved)) place_en = 1'b1;
      end
      S_UP_R1: begin
        pid_next = slot_rd;
        key_raddr = slot_rd[IW-1:0];
      end
      S_UP_R2: begin
        key_raddr = pid[IW-1:0];
        if (ckey < key_rd) begin
          place_en = 1'b1; place_id = pid;
          pos_next = parent;
          moved_next = 1'b1;
        end else if (!(try_down && !moved)) begin
          place_en = 1'b1;
        end
      end
      S_DN: begin
        slot_raddr = lc[SW-1:0];
        if (!lc_ok) place_en = 1'b1;
      end
      S_DL1: begin
        lid_next = slot_rd;
        key_raddr = slot_rd[IW-1:0];
        slot_raddr = rc[SW-1:0];
      end
      S_DL2: begin
        lkey_next = key_rd;
        rid_next = slot_rd;
        if (rc_ok) begin
          key_raddr = slot_rd[IW-1:0];
        end else begin
          place_en = 1'b1;
          if (dn_move) begin
            place_id = lid; pos_next = lc[SW-1:0];
          end
        end
      end
      S_DR: begin
        place_en = 1'b1;
        if (dn_move) begin
          place_id = pick_id; pos_next = pick_pos;
        end
      end
      S_FIN: slot_raddr = '0;
      S_FIN1: begin
        root_next = slot_rd;
        key_raddr = slot_rd[IW-1:0];
      end
      S_FIN2: key_raddr = root[IW-1:0];
      S_CLR: begin
        pres_we = 1'b1; pres_waddr = clr_idx;
        count_next = '0;
      end
      default: ;
    endcase
    slot_we    = place_en;
    slot_waddr = place_pos;
    slot_wdata = place_id;
    pos_we     = place_en;
    pos_waddr  = place_id[IW-1:0];
    pos_wdata  = place_pos;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (step == S_CLR) clr_idx <= clr_idx + 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_data.cmd;
      key_r <= in_data.key_value;
      id_r  <= in_data.item_id;
    end
    cid <= cid_next; ckey <= ckey_next; pid <= pid_next;
    lid <= lid_next; rid <= rid_next; lkey <= lkey_next;
    old_key <= old_key_next; root <= root_next; popped <= popped_next;
    pos <= pos_next; status <= status_next;
    q_present <= q_present_next; q_key <= q_key_next;
    try_down <= try_down_next; moved <= moved_next;
    if (out_load) begin
      out_data.status        <= status;
      out_data.min_valid     <= (count != '0);
      out_data.min_id        <= (count != '0) ? root : '0;
      out_data.min_key       <= (count != '0) ? key_rd : '0;
      out_data.popped_id     <= popped;
      out_data.query_present <= q_present;
      out_data.query_key     <= q_key;
      out_data.item_count    <= CNT_W'(count);
    end
  end

endmodule

### rtl/core/indexed_min_heap.sv
// Indexed binary min-heap over item ids 0..1023, one signed 32-bit key per id.
// Command channel (cmd_valid, cmd_stall, cmd_data): a transfer carries one
// command, an item id and a key. Response channel (rsp_valid, rsp_stall,
// rsp_data): exactly one response per command, in order, giving the status,
// the root id and key, the popped id, the query answer and the item count.
// Commands are taken one at a time; cmd_stall is high while one is at work.
// Each level of a sift up reads the parent slot and then the parent key on the
// single read ports of the slot and key memories; each level of a sift down
// reads the left and right child slots and keys.
// Clear sweeps the presence memory, one id per cycle; after reset the same
// sweep runs with cmd_stall high.
// A finished response waits in the output register while rsp_stall is high;
// the next command may be accepted meanwhile, and its response holds back
// until the register is free.
module indexed_min_heap #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  imh_pkg::in_item_t  cmd_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output imh_pkg::out_item_t rsp_data
);
  import imh_pkg::*;

  step_t      step;
  dp_status_t stat;
  logic       in_xfer;

  assign in_xfer = cmd_valid && !cmd_stall;

  // Sequencer.
  imh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .step     (step),
    .in_stall (cmd_stall)
  );

  // Heap memories and working registers.
  imh_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_xfer   (in_xfer),
    .in_data   (cmd_data),
    .stat      (stat),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .out_data  (rsp_data)
  );

endmodule
